// ----- design/uyvy_pkg.sv -----
// ----------------------------------------------------------------------------
// uyvy_pkg
// Shared constants, chroma term tables and helpers for the 4:2:2 to RGB888
// color converter.
// ----------------------------------------------------------------------------
package uyvy_pkg;

  localparam int Unit         = 1000;
  localparam int Half         = 500;
  localparam int ChromaOffset = 128;
  localparam int ChanMax      = 255;
  localparam int KRCr         = 1402;
  localparam int KGCb         = 344;
  localparam int KGCr         = 714;
  localparam int KBCb         = 1772;
  localparam int TabDepth     = 256;

  // quotient of a chroma term in whole channel steps, remainder in thousandths
  typedef logic signed [8:0] quot_t;
  typedef logic [9:0]        rem_t;
  typedef logic signed [9:0] sum_t;

  typedef quot_t quot_tab_t [TabDepth];
  typedef rem_t  rem_tab_t  [TabDepth];

  // per-group chroma contribution, already rounded, shared by both pixels
  typedef struct packed {
    quot_t r;
    quot_t g;
    quot_t b;
  } chroma_t;

  function automatic int floor_div(input int n);
    if (n >= 0) begin
      return n / Unit;
    end
    return -((-n + Unit - 1) / Unit);
  endfunction

  function automatic quot_tab_t build_quot(input int k, input int bias);
    quot_tab_t tab;
    int        n;
    for (int i = 0; i < TabDepth; i++) begin
      n      = k * (i - ChromaOffset) + bias;
      tab[i] = quot_t'(floor_div(n));
    end
    return tab;
  endfunction

  function automatic rem_tab_t build_rem(input int k, input int bias);
    rem_tab_t tab;
    int       n;
    for (int i = 0; i < TabDepth; i++) begin
      n      = k * (i - ChromaOffset) + bias;
      tab[i] = rem_t'(n - Unit * floor_div(n));
    end
    return tab;
  endfunction

  // rounding bias folded into the red, blue and cb part of green
  localparam quot_tab_t RQuot  = build_quot(KRCr, Half);
  localparam quot_tab_t BQuot  = build_quot(KBCb, Half);
  localparam quot_tab_t GbQuot = build_quot(-KGCb, Half);
  localparam rem_tab_t  GbRem  = build_rem(-KGCb, Half);
  localparam quot_tab_t GrQuot = build_quot(-KGCr, 0);
  localparam rem_tab_t  GrRem  = build_rem(-KGCr, 0);

  function automatic logic [7:0] clamp_chan(input sum_t v);
    if (v < 0) begin
      return 8'd0;
    end else if (v > sum_t'(ChanMax)) begin
      return 8'(ChanMax);
    end
    return v[7:0];
  endfunction

endpackage

// ----- design/uyvy_pixel.sv -----
// ----------------------------------------------------------------------------
// uyvy_pixel
// Adds the shared chroma terms to one luma value and clamps each channel.
// ----------------------------------------------------------------------------
module uyvy_pixel
  import uyvy_pkg::*;
(
  input  logic [7:0] luma_i,
  input  chroma_t    terms_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);

  sum_t luma_ext;
  sum_t red_sum;
  sum_t green_sum;
  sum_t blue_sum;

  assign luma_ext  = sum_t'({2'b00, luma_i});
  assign red_sum   = luma_ext + sum_t'({terms_i.r[8], terms_i.r});
  assign green_sum = luma_ext + sum_t'({terms_i.g[8], terms_i.g});
  assign blue_sum  = luma_ext + sum_t'({terms_i.b[8], terms_i.b});

  assign red_o   = clamp_chan(red_sum);
  assign green_o = clamp_chan(green_sum);
  assign blue_o  = clamp_chan(blue_sum);

endmodule

// ----- design/uyvy422_to_rgb888.sv -----
// ----------------------------------------------------------------------------
// uyvy422_to_rgb888
// BT.601 style 4:2:2 to RGB888 converter, one Cb Y0 Cr Y1 group per beat.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o with the four bytes of one group
//   (cb, y0, cr, y1); a beat is taken when valid is high and stall is low
//   output channel: out_valid_o / out_stall_i with two RGB888 pixels, left
//   pixel in the *_first ports, right pixel in the *_second ports
//   an accepted input beat passes the input register, then the result
//   register, before it appears as an output beat
//   throughput: one group per cycle while out_stall_i is low; the path is one
//   table read, the green remainder add and carry compare, the 9-bit green
//   quotient add, a 10-bit add and a clamp between the two register levels
//   reset: both valid flags clear, the block comes up empty and ready
//   stall: the result register holds its beat while out_stall_i is high;
//   the input register still takes a beat if it is empty, and in_stall_o
//   rises only once both register levels are full
//   chroma terms come from 256-entry constant tables; green sums two
//   remainders to find the rounding carry, so results match exact rounding
// ----------------------------------------------------------------------------
module uyvy422_to_rgb888
  import uyvy_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] chroma_blue_i,
  input  logic [7:0] luma_first_i,
  input  logic [7:0] chroma_red_i,
  input  logic [7:0] luma_second_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_first_o,
  output logic [7:0] green_first_o,
  output logic [7:0] blue_first_o,
  output logic [7:0] red_second_o,
  output logic [7:0] green_second_o,
  output logic [7:0] blue_second_o
);

  // input register
  logic       in_vld_q;
  logic [7:0] cb_q, y0_q, cr_q, y1_q;

  // result register
  logic       res_vld_q;
  logic [7:0] r0_q, g0_q, b0_q, r1_q, g1_q, b1_q;
  logic [7:0] r0_d, g0_d, b0_d, r1_d, g1_d, b1_d;

  logic res_ready;
  logic in_ready;

  // each level moves when it is empty or the next one moves
  assign res_ready  = !res_vld_q || !out_stall_i;
  assign in_ready   = !in_vld_q || res_ready;
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      cb_q <= chroma_blue_i;
      y0_q <= luma_first_i;
      cr_q <= chroma_red_i;
      y1_q <= luma_second_i;
    end
  end

  // chroma terms, shared by both pixels of the group
  chroma_t    terms;
  logic [10:0] g_rem_sum;
  logic        g_carry;

  always_comb begin
    g_rem_sum = {1'b0, GbRem[cb_q]} + {1'b0, GrRem[cr_q]};
    g_carry   = g_rem_sum >= 11'(Unit);
    terms.r   = RQuot[cr_q];
    terms.b   = BQuot[cb_q];
    terms.g   = GbQuot[cb_q] + GrQuot[cr_q] + quot_t'({8'b0, g_carry});
  end

  uyvy_pixel u_pix_first (
    .luma_i  (y0_q),
    .terms_i (terms),
    .red_o   (r0_d),
    .green_o (g0_d),
    .blue_o  (b0_d)
  );

  uyvy_pixel u_pix_second (
    .luma_i  (y1_q),
    .terms_i (terms),
    .red_o   (r1_d),
    .green_o (g1_d),
    .blue_o  (b1_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_ready) begin
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && in_vld_q) begin
      r0_q <= r0_d;
      g0_q <= g0_d;
      b0_q <= b0_d;
      r1_q <= r1_d;
      g1_q <= g1_d;
      b1_q <= b1_d;
    end
  end

  assign out_valid_o    = res_vld_q;
  assign red_first_o    = r0_q;
  assign green_first_o  = g0_q;
  assign blue_first_o   = b0_q;
  assign red_second_o   = r1_q;
  assign green_second_o = g1_q;
  assign blue_second_o  = b1_q;

endmodule

// ----- design/uyvy_checker.sv -----
// ----------------------------------------------------------------------------
// uyvy_checker
// Port-level checks of the converter's flow control, bound to the top level.
// ----------------------------------------------------------------------------
module uyvy_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] red_first_o,
  input logic [7:0] green_first_o,
  input logic [7:0] blue_first_o,
  input logic [7:0] red_second_o,
  input logic [7:0] green_second_o,
  input logic [7:0] blue_second_o
);

  logic [47:0] out_beat;
  assign out_beat = {red_first_o, green_first_o, blue_first_o,
                     red_second_o, green_second_o, blue_second_o};

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat))
    else $error("output beat changed while stalled");

  // an empty output side never backs up the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no output pending");

  // input stall only comes from a stalled output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");

  // an accepted group shows up at the output through the input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("accepted beat did not reach the output");

endmodule

bind uyvy422_to_rgb888 uyvy_checker u_uyvy_checker (.*);
